[rtl/gsacnt_pkg.sv]
// Shared types and character constants for the GSA satellite counter.
package gsacnt_pkg;

  // Class of one received byte, decided at the front.
  typedef enum logic [3:0] {
    K_CR,
    K_NL,
    K_ZERO,
    K_COMMA,
    K_STAR,
    K_DIGIT,
    K_SIGN,
    K_BLANK,
    K_OTHER
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic   valid;
    item_t  item;
  } queue_head_t;

  typedef struct packed {
    logic [3:0] gps_in_use;
    logic [3:0] glonass_in_use;
    logic [3:0] beidou_in_use;
    logic       count_updated;
  } result_t;

  // Parser state for the system id field after the last comma.
  typedef enum logic [1:0] {
    TAIL_SKIP,
    TAIL_DIGITS,
    TAIL_DONE
  } tail_phase_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;

  // "GSA," with the first character in the top byte.
  localparam logic [3:0][7:0] GSA_TAG = {8'h47, 8'h53, 8'h41, 8'h2C};
  localparam logic [7:0]      TAG_LEAD = 8'h47;

  localparam logic [23:0] TALKER_GP = 24'h244750;
  localparam logic [23:0] TALKER_GL = 24'h24474C;
  localparam logic [23:0] TALKER_BD = 24'h244244;
  localparam logic [23:0] TALKER_GB = 24'h244742;

  // Counters are widened to this size for compares against fixed limits.
  localparam int CMP_W = 8;
  localparam logic [CMP_W-1:0] MIN_LINE_LEN  = 8'd10;
  localparam logic [CMP_W-1:0] ID_COMMAS     = 8'd18;
  localparam logic [CMP_W-1:0] TALKER_COMMAS = 8'd17;
  localparam logic [CMP_W-1:0] FIRST_SLOT    = 8'd3;
  localparam logic [CMP_W-1:0] LAST_SLOT     = 8'd14;
  localparam logic [3:0]       MAX_SLOTS     = 4'd12;

  localparam logic [3:0] SYS_NONE    = 4'd0;
  localparam logic [3:0] SYS_GPS     = 4'd1;
  localparam logic [3:0] SYS_GLONASS = 4'd2;
  localparam logic [3:0] SYS_BEIDOU  = 4'd4;
  // Id value of five or more: never a known system.
  localparam logic [3:0] TAIL_BIG    = 4'hF;

endpackage

[rtl/gsacnt_in_if.sv]
// Byte stream channel into the GSA satellite counter.
interface gsacnt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/gsacnt_out_if.sv]
// Satellite count channel out of the GSA satellite counter.
interface gsacnt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] gps_in_use;
  logic [3:0] glonass_in_use;
  logic [3:0] beidou_in_use;
  logic       count_updated;

  modport source (output valid, output gps_in_use, output glonass_in_use,
                  output beidou_in_use, output count_updated, input ready);
  modport sink (input valid, input gps_in_use, input glonass_in_use,
                input beidou_in_use, input count_updated, output ready);
endinterface

[rtl/gsacnt_front.sv]
// Front end: accept bytes, classify them and push them into the queue.
module gsacnt_front import gsacnt_pkg::*; (
  input  logic       rx_valid,
  input  logic [7:0] rx_byte,
  output logic       rx_ready,
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  byte_kind_t kind;

  always_comb begin
    if (rx_byte == CH_CR) begin
      kind = K_CR;
    end else if (rx_byte == CH_LF) begin
      kind = K_NL;
    end else if (rx_byte == CH_NUL) begin
      kind = K_ZERO;
    end else if (rx_byte == CH_COMMA) begin
      kind = K_COMMA;
    end else if (rx_byte == CH_STAR) begin
      kind = K_STAR;
    end else if (rx_byte >= CH_DIG0 && rx_byte <= CH_DIG9) begin
      kind = K_DIGIT;
    end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
      kind = K_SIGN;
    end else if (rx_byte == CH_SPACE || rx_byte == CH_TAB ||
                 rx_byte == CH_VT || rx_byte == CH_FF) begin
      kind = K_BLANK;
    end else begin
      kind = K_OTHER;
    end
  end

  assign rx_ready       = !queue_full;
  assign push           = rx_valid && !queue_full;
  assign push_item.kind = kind;
  assign push_item.data = rx_byte;

endmodule

[rtl/gsacnt_fifo.sv]
// Short queue between the classifier and the line engine.
module gsacnt_fifo import gsacnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/gsacnt_back.sv]
// Line engine: track one line byte by byte, store counts at newline.
module gsacnt_back import gsacnt_pkg::*; #(
  parameter int LINE_BYTES = 82
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output result_t     result
);

  localparam int LEN_W = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0] LINE_CAP = LEN_W'(LINE_BYTES - 1);

  logic [LEN_W-1:0] line_length, line_length_next;
  logic [LEN_W-1:0] comma_total, comma_total_next;
  logic             star_seen, star_seen_next;
  logic             after_comma, after_comma_next;
  logic [3:0]       slot_count, slot_count_next;
  logic [3:0]       tail_value, tail_value_next;
  tail_phase_t      tail_phase, tail_phase_next;
  logic             tail_neg, tail_neg_next;
  logic [23:0]      talker_prefix, talker_prefix_next;
  logic [1:0]       prefix_count, prefix_count_next;
  logic [1:0]       tag_match_stage, tag_match_stage_next;
  logic             tag_found, tag_found_next;
  logic             text_closed, text_closed_next;
  logic [3:0]       gps_count, gps_count_next;
  logic [3:0]       glonass_count, glonass_count_next;
  logic [3:0]       beidou_count, beidou_count_next;
  logic             out_valid_next;
  result_t          result_next;

  item_t      item;
  logic       line_clear;
  logic       updated;
  logic       line_ok;
  logic [3:0] sys_id;
  logic [3:0] talker_sys;
  logic [3:0] digit_acc;
  logic [5:0] digit_sum;

  assign item = head.item;
  assign pop  = head.valid && (!out_valid || out_ready);

  // Id so far times ten plus the new digit; anything past four is unknown.
  always_comb begin
    digit_sum = 6'(tail_value) * 6'd10 + 6'(item.data[3:0]);
    if (tail_value == TAIL_BIG || digit_sum > 6'(SYS_BEIDOU)) begin
      digit_acc = TAIL_BIG;
    end else begin
      digit_acc = digit_sum[3:0];
    end
  end

  always_comb begin
    if (prefix_count != 2'd3) begin
      talker_sys = SYS_NONE;
    end else if (talker_prefix == TALKER_GP) begin
      talker_sys = SYS_GPS;
    end else if (talker_prefix == TALKER_GL) begin
      talker_sys = SYS_GLONASS;
    end else if (talker_prefix == TALKER_BD || talker_prefix == TALKER_GB) begin
      talker_sys = SYS_BEIDOU;
    end else begin
      talker_sys = SYS_NONE;
    end
  end

  always_comb begin
    if (CMP_W'(comma_total) >= ID_COMMAS) begin
      sys_id = tail_neg ? SYS_NONE : tail_value;
    end else if (CMP_W'(comma_total) == TALKER_COMMAS) begin
      sys_id = talker_sys;
    end else begin
      sys_id = SYS_NONE;
    end
  end

  assign line_ok = (CMP_W'(line_length) > MIN_LINE_LEN) && tag_found && star_seen;

  always_comb begin
    line_length_next     = line_length;
    comma_total_next     = comma_total;
    star_seen_next       = star_seen;
    after_comma_next     = after_comma;
    slot_count_next      = slot_count;
    tail_value_next      = tail_value;
    tail_phase_next      = tail_phase;
    tail_neg_next        = tail_neg;
    talker_prefix_next   = talker_prefix;
    prefix_count_next    = prefix_count;
    tag_match_stage_next = tag_match_stage;
    tag_found_next       = tag_found;
    text_closed_next     = text_closed;
    gps_count_next       = gps_count;
    glonass_count_next   = glonass_count;
    beidou_count_next    = beidou_count;
    line_clear           = 1'b0;
    updated              = 1'b0;
    out_valid_next       = out_valid && !out_ready;

    if (pop) begin
      out_valid_next = 1'b1;
      case (item.kind)
        K_CR: begin
        end
        K_NL: begin
          line_clear = 1'b1;
          if (line_ok) begin
            case (sys_id)
              SYS_GPS: begin
                gps_count_next = slot_count;
                updated        = 1'b1;
              end
              SYS_GLONASS: begin
                glonass_count_next = slot_count;
                updated            = 1'b1;
              end
              SYS_BEIDOU: begin
                beidou_count_next = slot_count;
                updated           = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          if (line_length == LINE_CAP) begin
            line_clear = 1'b1;
          end else begin
            line_length_next = line_length + 1'b1;
            if (!text_closed) begin
              if (item.kind == K_ZERO) begin
                text_closed_next = 1'b1;
              end else begin
                // Tag search runs over the whole text.
                if (item.data == GSA_TAG[2'd3 - tag_match_stage]) begin
                  if (tag_match_stage == 2'd3) begin
                    tag_found_next       = 1'b1;
                    tag_match_stage_next = '0;
                  end else begin
                    tag_match_stage_next = tag_match_stage + 1'b1;
                  end
                end else if (item.data == TAG_LEAD) begin
                  tag_match_stage_next = 2'd1;
                end else begin
                  tag_match_stage_next = '0;
                end

                if (!star_seen) begin
                  if (prefix_count != 2'd3 && item.kind != K_STAR) begin
                    talker_prefix_next = {talker_prefix[15:0], item.data};
                    prefix_count_next  = prefix_count + 1'b1;
                  end
                  case (item.kind)
                    K_STAR: begin
                      star_seen_next = 1'b1;
                    end
                    K_COMMA: begin
                      comma_total_next = comma_total + 1'b1;
                      after_comma_next = 1'b1;
                      tail_phase_next  = TAIL_SKIP;
                      tail_value_next  = '0;
                      tail_neg_next    = 1'b0;
                    end
                    default: begin
                      if (after_comma && CMP_W'(comma_total) >= FIRST_SLOT &&
                          CMP_W'(comma_total) <= LAST_SLOT) begin
                        slot_count_next = slot_count + 1'b1;
                      end
                      after_comma_next = 1'b0;
                      case (tail_phase)
                        TAIL_SKIP: begin
                          if (item.kind == K_SIGN) begin
                            tail_phase_next = TAIL_DIGITS;
                            tail_neg_next   = (item.data == CH_MINUS);
                          end else if (item.kind == K_DIGIT) begin
                            tail_phase_next = TAIL_DIGITS;
                            tail_value_next = digit_acc;
                          end else if (item.kind != K_BLANK) begin
                            tail_phase_next = TAIL_DONE;
                          end
                        end
                        TAIL_DIGITS: begin
                          if (item.kind == K_DIGIT) begin
                            tail_value_next = digit_acc;
                          end else begin
                            tail_phase_next = TAIL_DONE;
                          end
                        end
                        default: begin
                        end
                      endcase
                    end
                  endcase
                end
              end
            end
          end
        end
      endcase
    end

    if (line_clear) begin
      line_length_next     = '0;
      comma_total_next     = '0;
      star_seen_next       = 1'b0;
      after_comma_next     = 1'b0;
      slot_count_next      = '0;
      tail_value_next      = '0;
      tail_phase_next      = TAIL_SKIP;
      tail_neg_next        = 1'b0;
      talker_prefix_next   = '0;
      prefix_count_next    = '0;
      tag_match_stage_next = '0;
      tag_found_next       = 1'b0;
      text_closed_next     = 1'b0;
    end

    result_next.gps_in_use     = gps_count_next;
    result_next.glonass_in_use = glonass_count_next;
    result_next.beidou_in_use  = beidou_count_next;
    result_next.count_updated  = updated;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      comma_total     <= '0;
      star_seen       <= 1'b0;
      after_comma     <= 1'b0;
      slot_count      <= '0;
      tail_value      <= '0;
      tail_phase      <= TAIL_SKIP;
      tail_neg        <= 1'b0;
      talker_prefix   <= '0;
      prefix_count    <= '0;
      tag_match_stage <= '0;
      tag_found       <= 1'b0;
      text_closed     <= 1'b0;
      gps_count       <= '0;
      glonass_count   <= '0;
      beidou_count    <= '0;
      out_valid       <= 1'b0;
    end else begin
      line_length     <= line_length_next;
      comma_total     <= comma_total_next;
      star_seen       <= star_seen_next;
      after_comma     <= after_comma_next;
      slot_count      <= slot_count_next;
      tail_value      <= tail_value_next;
      tail_phase      <= tail_phase_next;
      tail_neg        <= tail_neg_next;
      talker_prefix   <= talker_prefix_next;
      prefix_count    <= prefix_count_next;
      tag_match_stage <= tag_match_stage_next;
      tag_found       <= tag_found_next;
      text_closed     <= text_closed_next;
      gps_count       <= gps_count_next;
      glonass_count   <= glonass_count_next;
      beidou_count    <= beidou_count_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_count <= MAX_SLOTS)
    else $error("slot count above twelve");

  a_commas_in_line: assert property (@(posedge clk) disable iff (rst)
    comma_total <= line_length)
    else $error("more commas than stored bytes");

  a_newline_clears: assert property (@(posedge clk) disable iff (rst)
    pop && item.kind == K_NL |=> out_valid && line_length == '0 && !tag_found)
    else $error("line state kept after newline");

  a_counts_range: assert property (@(posedge clk) disable iff (rst)
    gps_count <= MAX_SLOTS && glonass_count <= MAX_SLOTS && beidou_count <= MAX_SLOTS)
    else $error("stored count above twelve");

endmodule

[rtl/nmea_gsa_satellite_counter.sv]
// Top level of the NMEA GSA satellite counter: classifier, queue, line engine.
//
//   channel   role    payload                                          word
//   stream    sink    rx_byte[7:0]                                     one byte
//   counts    source  gps_in_use, glonass_in_use, beidou_in_use [3:0],
//                     count_updated                                    one per byte
//
// Takes one byte per cycle while counts is ready and returns one word per byte,
// every byte included. Each byte is held in the two-word queue, then the line
// engine updates the per-line trackers and registers the count word.
// Synchronous active-high rst clears the queue, the line trackers and counts.
// A stall on counts fills the queue; stream ready drops only when it is full.
module nmea_gsa_satellite_counter import gsacnt_pkg::*; #(
  parameter int LINE_BYTES = 82
) (
  input  logic          clk,
  input  logic          rst,
  gsacnt_in_if.sink     stream,
  gsacnt_out_if.source  counts
);

  logic        queue_full;
  logic        push;
  item_t       push_item;
  logic        pop;
  queue_head_t head;
  result_t     result;

  // Classify each byte as it is accepted.
  gsacnt_front u_front (
    .rx_valid   (stream.valid),
    .rx_byte    (stream.rx_byte),
    .rx_ready   (stream.ready),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Hold classified bytes while the output side stalls.
  gsacnt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  // Advance the line trackers and register the count word.
  gsacnt_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_ready (counts.ready),
    .out_valid (counts.valid),
    .result    (result)
  );

  assign counts.gps_in_use     = result.gps_in_use;
  assign counts.glonass_in_use = result.glonass_in_use;
  assign counts.beidou_in_use  = result.beidou_in_use;
  assign counts.count_updated  = result.count_updated;

endmodule
